### hw/rtl/melody_tone_sequencer_defines.svh
// Assertion macros shared by the melody tone sequencer RTL
`ifndef MELODY_TONE_SEQUENCER_DEFINES_SVH
`define MELODY_TONE_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clk edge outside of reset
`define MTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside of reset
`define MTS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define MTS_ASSERT(lbl, prop, msg)
`define MTS_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

### hw/rtl/mts_pkg.sv
// Types, operation codes and sizes for the melody tone sequencer
`timescale 1ns / 1ps

package mts_pkg;

  localparam int NOTE_DEPTH   = 256;
  localparam int NOTE_AW      = $clog2(NOTE_DEPTH);
  localparam int MELODY_COUNT = 16;
  localparam int MELODY_AW    = (MELODY_COUNT > 1) ? $clog2(MELODY_COUNT) : 1;

  localparam logic [7:0] GAP_LENGTH = 8'd255;
  localparam logic [7:0] ENDLESS    = 8'd255;

  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_PLAY      = 3'd1;
  localparam logic [2:0] OP_STOP      = 3'd2;
  localparam logic [2:0] OP_WR_NOTE   = 3'd3;
  localparam logic [2:0] OP_WR_MELODY = 3'd4;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  index;
    logic [7:0]  start_note;
    logic [15:0] tone_freq_in;
    logic [15:0] note_ticks;
    logic [7:0]  repeats;
  } in_item_t;

  typedef struct packed {
    logic [15:0] tone_freq;
    logic        tone_update;
    logic        playing;
  } out_item_t;

  typedef struct packed {
    logic [15:0] freq;
    logic [15:0] len;
  } note_entry_t;

  typedef struct packed {
    logic               we;
    logic [NOTE_AW-1:0] waddr;
    note_entry_t        wdata;
    logic [NOTE_AW-1:0] raddr;
  } note_req_t;

endpackage

### hw/rtl/mts_note_ram.sv
// Note store: one write port, one registered read port with write bypass
`timescale 1ns / 1ps

module mts_note_ram
  import mts_pkg::*;
(
  input  logic        clk,
  input  note_req_t   req,
  output note_entry_t rd_entry
);

  note_entry_t mem [NOTE_DEPTH];
  note_entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    // forward a same-cycle write so the read stays current
    if (req.we && (req.waddr == req.raddr)) begin
      rd_entry_r <= req.wdata;
    end else begin
      rd_entry_r <= mem[req.raddr];
    end
  end

  assign rd_entry = rd_entry_r;

endmodule

### hw/rtl/mts_core.sv
// Player state, melody start table and per-item update logic
`timescale 1ns / 1ps

`include "melody_tone_sequencer_defines.svh"

module mts_core
  import mts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  in_item_t    item,
  input  note_entry_t entry,
  output out_item_t   result,
  output note_req_t   ram_req
);

  logic [NOTE_AW-1:0] mel_first_r [MELODY_COUNT];

  logic [NOTE_AW-1:0] cur_r, cur_nxt;
  logic [NOTE_AW-1:0] restart_r, restart_nxt;
  logic [15:0]        tick_r, tick_nxt;
  logic [7:0]         rep_r, rep_nxt;
  logic [7:0]         gap_r, gap_nxt;
  logic               active_r, active_nxt;
  logic [15:0]        tone_r, tone_nxt;

  logic [7:0]         rep_dec;
  logic [15:0]        tick_inc;
  logic               update;
  logic [MELODY_AW-1:0] mel_sel;

  assign mel_sel  = item.index[MELODY_AW-1:0];
  assign rep_dec  = (rep_r != ENDLESS) ? (rep_r - 8'd1) : rep_r;
  assign tick_inc = tick_r + 16'd1;

  always_comb begin
    cur_nxt       = cur_r;
    restart_nxt   = restart_r;
    tick_nxt      = tick_r;
    rep_nxt       = rep_r;
    gap_nxt       = gap_r;
    active_nxt    = active_r;
    tone_nxt      = tone_r;
    update        = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = item.index[NOTE_AW-1:0];
    ram_req.wdata = '{freq: item.tone_freq_in, len: item.note_ticks};
    if (fire) begin
      unique case (item.operation)
        OP_TICK: begin
          if (active_r) begin
            if (gap_r != 8'd0) begin
              gap_nxt = gap_r - 8'd1;
            end else begin
              update = 1'b1;
              if (entry.len == 16'd0) begin
                // end marker: silence, then restart after the gap or stop
                tone_nxt = 16'd0;
                rep_nxt  = rep_dec;
                if (rep_dec != 8'd0) begin
                  cur_nxt = restart_r;
                  gap_nxt = GAP_LENGTH;
                end else begin
                  active_nxt = 1'b0;
                end
              end else begin
                tone_nxt = entry.freq;
                if (tick_inc >= entry.len) begin
                  cur_nxt  = cur_r + NOTE_AW'(1);
                  tick_nxt = 16'd0;
                end else begin
                  tick_nxt = tick_inc;
                end
              end
            end
          end
        end
        OP_PLAY: begin
          cur_nxt     = mel_first_r[mel_sel];
          restart_nxt = mel_first_r[mel_sel];
          tick_nxt    = 16'd0;
          rep_nxt     = (item.repeats == 8'd0) ? ENDLESS : item.repeats;
          gap_nxt     = 8'd0;
          active_nxt  = 1'b1;
        end
        OP_STOP: begin
          active_nxt = 1'b0;
        end
        OP_WR_NOTE: begin
          ram_req.we = 1'b1;
        end
        OP_WR_MELODY: begin
        end
        default: begin
        end
      endcase
    end
    // read ahead at the next note so the entry lines up with cur_r
    ram_req.raddr = cur_nxt;
    result = '{tone_freq: tone_nxt, tone_update: update, playing: active_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r     <= '0;
      restart_r <= '0;
      tick_r    <= '0;
      rep_r     <= '0;
      gap_r     <= '0;
      active_r  <= 1'b0;
      tone_r    <= '0;
    end else begin
      cur_r     <= cur_nxt;
      restart_r <= restart_nxt;
      tick_r    <= tick_nxt;
      rep_r     <= rep_nxt;
      gap_r     <= gap_nxt;
      active_r  <= active_nxt;
      tone_r    <= tone_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (item.operation == OP_WR_MELODY)) begin
      mel_first_r[mel_sel] <= item.start_note[NOTE_AW-1:0];
    end
  end

  `MTS_ASSERT(a_gap_has_repeats, (gap_r != 8'd0) |-> (rep_r != 8'd0), "gap pending with no repeats left")
  `MTS_ASSERT(a_play_starts_clean, (fire && (item.operation == OP_PLAY)) |=> (active_r && (gap_r == 8'd0) && (tick_r == 16'd0)), "play did not start cleanly")
  `MTS_ASSERT_NEVER(a_idle_no_update, fire && !active_r && update, "tone update while idle")

endmodule

### hw/rtl/melody_tone_sequencer.sv
// Top level of the melody tone sequencer: input stage, core, note store, result register
`timescale 1ns / 1ps

//  channel | ports                          | payload     | direction
//  --------+--------------------------------+-------------+----------
//  in      | in_valid, in_ready, in_data    | in_item_t   | input
//  out     | out_valid, out_ready, out_data | out_item_t  | output
//
//  One item per cycle sustained while the result is not stalled; each item gives
//  exactly one result, which passes from the input register through the core into
//  the result register, from which it is offered on the output handshake.
//  The note store is read one item ahead at the next note address, so a tick
//  finds its note entry already registered; a note write to that address is
//  bypassed into the read register.
//  Synchronous active-low reset clears control state only; the note store and
//  the melody start table come up undefined and take no clearing pass.
//  A stalled result holds in the result register while the input register
//  still takes one more item.

`include "melody_tone_sequencer_defines.svh"

module melody_tone_sequencer
  import mts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic        in_valid_r;
  in_item_t    item_r;
  logic        out_valid_r;
  out_item_t   out_r;

  logic        proceed;
  out_item_t   result;
  note_req_t   ram_req;
  note_entry_t entry;

  // advance the held item whenever the result register is free or draining
  assign proceed  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || proceed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (proceed) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers: capture on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (proceed) begin
      out_r <= result;
    end
  end

  mts_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (proceed),
    .item    (item_r),
    .entry   (entry),
    .result  (result),
    .ram_req (ram_req)
  );

  mts_note_ram u_note_ram (
    .clk      (clk),
    .req      (ram_req),
    .rd_entry (entry)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `MTS_ASSERT(a_in_stage_holds,
              (in_valid_r && out_valid_r && !out_ready) |=> (in_valid_r && $stable(item_r)),
              "held item lost while result stalled")
  `MTS_ASSERT_NEVER(a_no_write_when_idle, ram_req.we && !proceed,
                    "note write without an item")

endmodule
